/* sv/hpt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// shared types, widths and arithmetic helpers for the homogeneous point transform
// no dependencies
package hpt_pkg;

	localparam int COORD_W     = 32;
	localparam int COEF_W      = 16;
	localparam int ROW_W       = 64;
	localparam int NUM_ROWS    = 4;
	localparam int NUM_LANES   = 3;
	localparam int PROD_W      = COORD_W + COEF_W;
	localparam int ACC_W       = 50;
	localparam int MAG_W       = ACC_W - 1;
	localparam int REM_W       = MAG_W + 1;
	localparam int FRAC_SH     = 16;
	localparam int PASS_SH     = 8;
	localparam int PASS_W      = MAG_W - PASS_SH;
	localparam int Q_W         = 32;
	localparam int DIV_STAGES  = Q_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;
	localparam int CFG_IDX_W   = 8;

	localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_0100;
	localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_0100_0000;
	localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_0100_0000_0000;
	localparam logic [ROW_W-1:0] ROW3_RESET = 64'h0100_0000_0000_0000;

	localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [COORD_W-1:0] in_x;
		logic signed [COORD_W-1:0] in_y;
		logic signed [COORD_W-1:0] in_z;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic                      w_was_zero;
		logic                      clipped;
	} out_word_t;

	typedef logic [NUM_ROWS-1:0][ROW_W-1:0] matrix_t;
	typedef logic [NUM_ROWS-1:0][ACC_W-1:0] acc_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [Q_W-1:0]   low;
		logic [Q_W-1:0]   quo;
	} lane_t;

	typedef struct packed {
		logic                               wz;
		logic [MAG_W-1:0]                   den;
		logic [NUM_LANES-1:0]               neg;
		logic [NUM_LANES-1:0]               ovf;
		logic [NUM_LANES-1:0][COORD_W-1:0]  pass;
		logic [NUM_LANES-1:0]               pclip;
	} side_t;

	function automatic logic [MAG_W-1:0] mag_of(input logic [ACC_W-1:0] a);
		logic [ACC_W-1:0] n;
		begin
			n = ACC_W'(0) - a;
			mag_of = a[ACC_W-1] ? n[MAG_W-1:0] : a[MAG_W-1:0];
		end
	endfunction

	// returns {clip, value}
	function automatic logic [COORD_W:0] sat_q(input logic neg, input logic [PASS_W-1:0] m);
		logic [COORD_W-1:0] v;
		begin
			v = COORD_W'(0) - m[COORD_W-1:0];
			if (neg) begin
				if (m > PASS_W'(SAT_MIN))
					sat_q = {1'b1, SAT_MIN};
				else
					sat_q = {1'b0, v};
			end else begin
				if (m > PASS_W'(SAT_MAX))
					sat_q = {1'b1, SAT_MAX};
				else
					sat_q = {1'b0, m[COORD_W-1:0]};
			end
		end
	endfunction

	// one restoring step, one quotient bit
	function automatic lane_t div_step(input lane_t l, input logic [MAG_W-1:0] den);
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] d;
		lane_t r;
		begin
			t = {l.rem[REM_W-2:0], l.low[Q_W-1]};
			d = REM_W'(den);
			r.low = {l.low[Q_W-2:0], 1'b0};
			if (t >= d) begin
				r.rem = t - d;
				r.quo = {l.quo[Q_W-2:0], 1'b1};
			end else begin
				r.rem = t;
				r.quo = {l.quo[Q_W-2:0], 1'b0};
			end
			div_step = r;
		end
	endfunction

endpackage
`default_nettype wire

/* sv/homogeneous_point_transform_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// homogeneous point transform: point times 4x4 q8.8 matrix, perspective divide
// input word: in_x, in_y, in_z in q16.16, taken when in_valid is high and in_stall low
// output word: out_x/y/z in q16.16 plus w_was_zero and clipped, taken when
//   out_valid is high and out_stall low
// configuration: cfg_valid/cfg_ready write of one 64-bit matrix row by cfg_index,
//   indexes above three are ignored; cfg_ready is always high
// throughput: one word per cycle while in_stall and out_stall stay low
// path: two front stages (the first loads at the accepting edge), the queue, one set-up
//   stage, the 32-stage restoring divider (one quotient bit per stage) and the output
//   register
// reset: matrix returns to identity, pipeline and queue empty
// out_stall freezes the back end while out_valid is high; the front keeps filling
//   the four-word queue, and in_stall rises once it is full with a word waiting
// depends on hpt_pkg, hpt_front, hpt_queue, hpt_back
module homogeneous_point_transform_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire hpt_pkg::in_word_t              in_word,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output hpt_pkg::out_word_t                  out_word,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [hpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hpt_pkg::ROW_W-1:0]      cfg_data
);

	hpt_pkg::matrix_t     matrix_q;
	hpt_pkg::queue_stat_t qstat;
	hpt_pkg::acc_word_t   push_word, head_word;
	logic push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q[0] <= hpt_pkg::ROW0_RESET;
			matrix_q[1] <= hpt_pkg::ROW1_RESET;
			matrix_q[2] <= hpt_pkg::ROW2_RESET;
			matrix_q[3] <= hpt_pkg::ROW3_RESET;
		end else if (cfg_valid && cfg_ready &&
				cfg_index < hpt_pkg::CFG_IDX_W'(hpt_pkg::NUM_ROWS)) begin
			matrix_q[cfg_index[1:0]] <= cfg_data;
		end
	end

	hpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.matrix    (matrix_q),
		.qstat     (qstat),
		.push      (push),
		.push_word (push_word)
	);

	hpt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head_word (head_word),
		.qstat     (qstat)
	);

	hpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_word (head_word),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule
`default_nettype wire

/* sv/hpt_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// front end: takes a point word, forms the four matrix column sums
// depends on hpt_pkg
module hpt_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire hpt_pkg::in_word_t in_word,
	input  wire hpt_pkg::matrix_t  matrix,
	input  wire hpt_pkg::queue_stat_t qstat,
	output logic                  push,
	output hpt_pkg::acc_word_t    push_word
);

	logic en;
	logic v_s1, v_s2;
	logic signed [hpt_pkg::PROD_W-1:0] prod_s1 [hpt_pkg::NUM_ROWS][hpt_pkg::NUM_LANES];
	logic signed [hpt_pkg::COEF_W-1:0] trans_s1 [hpt_pkg::NUM_ROWS];
	hpt_pkg::acc_word_t acc_s2;
	logic signed [hpt_pkg::COORD_W-1:0] coord [hpt_pkg::NUM_LANES];

	assign en       = !(v_s2 && qstat.full);
	assign in_stall = !en;
	assign push     = v_s2 && en;
	assign push_word = acc_s2;

	assign coord[0] = in_word.in_x;
	assign coord[1] = in_word.in_y;
	assign coord[2] = in_word.in_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < hpt_pkg::NUM_ROWS; c++) begin
				for (int r = 0; r < hpt_pkg::NUM_LANES; r++)
					prod_s1[c][r] <= hpt_pkg::PROD_W'(coord[r] *
						$signed(matrix[r][c*hpt_pkg::COEF_W +: hpt_pkg::COEF_W]));
				trans_s1[c] <= $signed(matrix[hpt_pkg::NUM_ROWS-1][c*hpt_pkg::COEF_W +:
					hpt_pkg::COEF_W]);
			end
		end
	end

	// column sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < hpt_pkg::NUM_ROWS; c++)
				acc_s2[c] <= hpt_pkg::ACC_W'(prod_s1[c][0]) + hpt_pkg::ACC_W'(prod_s1[c][1])
					+ hpt_pkg::ACC_W'(prod_s1[c][2])
					+ (hpt_pkg::ACC_W'(trans_s1[c]) <<< hpt_pkg::FRAC_SH);
		end
	end

endmodule
`default_nettype wire

/* sv/hpt_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// short word queue between front and back ends
// depends on hpt_pkg
module hpt_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire hpt_pkg::acc_word_t push_word,
	input  wire logic               pop,
	output hpt_pkg::acc_word_t      head_word,
	output hpt_pkg::queue_stat_t    qstat
);

	hpt_pkg::acc_word_t mem_q [hpt_pkg::QUEUE_DEPTH];
	logic [hpt_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [hpt_pkg::QCNT_W-1:0] cnt_q;

	assign qstat.full  = (cnt_q == hpt_pkg::QCNT_W'(hpt_pkg::QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head_word   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_word;
	end

endmodule
`default_nettype wire

/* sv/hpt_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// back end: magnitudes, pipelined restoring divide by w, saturation, output register
// depends on hpt_pkg
module hpt_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hpt_pkg::acc_word_t head_word,
	input  wire hpt_pkg::queue_stat_t qstat,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output hpt_pkg::out_word_t      out_word
);

	logic en;
	logic [hpt_pkg::DIV_STAGES:0] vld_s;
	hpt_pkg::side_t side_s [hpt_pkg::DIV_STAGES+1];
	hpt_pkg::lane_t lane_s [hpt_pkg::DIV_STAGES+1][hpt_pkg::NUM_LANES];
	logic out_valid_q;
	hpt_pkg::out_word_t out_word_q;

	hpt_pkg::side_t side_in;
	hpt_pkg::lane_t lane_in [hpt_pkg::NUM_LANES];
	logic [hpt_pkg::MAG_W-1:0] mag_c [hpt_pkg::NUM_LANES];
	logic [hpt_pkg::COORD_W:0] pass_c [hpt_pkg::NUM_LANES];
	logic [hpt_pkg::COORD_W:0] res_c [hpt_pkg::NUM_LANES];
	logic [hpt_pkg::COORD_W-1:0] val_c [hpt_pkg::NUM_LANES];
	logic [hpt_pkg::NUM_LANES-1:0] clip_c;
	logic w_neg;

	assign en        = !out_valid_q || !out_stall;
	assign pop       = en && !qstat.empty;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// classify and set up the divide
	always_comb begin
		side_in.den = hpt_pkg::mag_of(head_word[hpt_pkg::NUM_ROWS-1]);
		side_in.wz  = (head_word[hpt_pkg::NUM_ROWS-1] == '0);
		w_neg       = head_word[hpt_pkg::NUM_ROWS-1][hpt_pkg::ACC_W-1];
		for (int l = 0; l < hpt_pkg::NUM_LANES; l++) begin
			mag_c[l]  = hpt_pkg::mag_of(head_word[l]);
			pass_c[l] = hpt_pkg::sat_q(head_word[l][hpt_pkg::ACC_W-1],
				mag_c[l][hpt_pkg::MAG_W-1:hpt_pkg::PASS_SH]);
			side_in.pass[l]  = pass_c[l][hpt_pkg::COORD_W-1:0];
			side_in.pclip[l] = pass_c[l][hpt_pkg::COORD_W];
			side_in.neg[l]   = side_in.wz ? head_word[l][hpt_pkg::ACC_W-1]
				: (head_word[l][hpt_pkg::ACC_W-1] ^ w_neg);
			side_in.ovf[l]   = {hpt_pkg::FRAC_SH'(0), mag_c[l]} >=
				{side_in.den, hpt_pkg::FRAC_SH'(0)};
			lane_in[l].rem = hpt_pkg::REM_W'(mag_c[l][hpt_pkg::MAG_W-1:hpt_pkg::FRAC_SH]);
			lane_in[l].low = {mag_c[l][hpt_pkg::FRAC_SH-1:0], hpt_pkg::FRAC_SH'(0)};
			lane_in[l].quo = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[hpt_pkg::DIV_STAGES-1:0], !qstat.empty};
			out_valid_q <= vld_s[hpt_pkg::DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int l = 0; l < hpt_pkg::NUM_LANES; l++)
				lane_s[0][l] <= lane_in[l];
			for (int k = 0; k < hpt_pkg::DIV_STAGES; k++) begin
				side_s[k+1] <= side_s[k];
				for (int l = 0; l < hpt_pkg::NUM_LANES; l++)
					lane_s[k+1][l] <= hpt_pkg::div_step(lane_s[k][l], side_s[k].den);
			end
		end
	end

	// final selection and saturation
	always_comb begin
		for (int l = 0; l < hpt_pkg::NUM_LANES; l++) begin
			res_c[l] = hpt_pkg::sat_q(side_s[hpt_pkg::DIV_STAGES].neg[l],
				hpt_pkg::PASS_W'(lane_s[hpt_pkg::DIV_STAGES][l].quo));
			if (side_s[hpt_pkg::DIV_STAGES].wz) begin
				val_c[l]  = side_s[hpt_pkg::DIV_STAGES].pass[l];
				clip_c[l] = side_s[hpt_pkg::DIV_STAGES].pclip[l];
			end else if (side_s[hpt_pkg::DIV_STAGES].ovf[l]) begin
				val_c[l]  = side_s[hpt_pkg::DIV_STAGES].neg[l] ? hpt_pkg::SAT_MIN
					: hpt_pkg::SAT_MAX;
				clip_c[l] = 1'b1;
			end else begin
				val_c[l]  = res_c[l][hpt_pkg::COORD_W-1:0];
				clip_c[l] = res_c[l][hpt_pkg::COORD_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word_q.out_x      <= val_c[0];
			out_word_q.out_y      <= val_c[1];
			out_word_q.out_z      <= val_c[2];
			out_word_q.w_was_zero <= side_s[hpt_pkg::DIV_STAGES].wz;
			out_word_q.clipped    <= |clip_c;
		end
	end

endmodule
`default_nettype wire

/* tb/sv/homogeneous_point_transform_top_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for the homogeneous point transform: directed table then random
// matrices and points, each output word checked against its table entry or a local model of the datapath
// depends on hpt_pkg and homogeneous_point_transform_top
module homogeneous_point_transform_top_tb;
	import hpt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'd200;
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 60;
	localparam int RAND_PHASES = 8;
	localparam int RAND_POINTS = 163;

	typedef enum logic {DIR_POINT, DIR_CFG} dir_kind_t;

	typedef struct {
		dir_kind_t          kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [ROW_W-1:0]   data;
		in_word_t           pt;
		logic               has_exp;
		out_word_t          exp;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_word;
	logic out_valid;
	logic out_stall;
	out_word_t out_word;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ROW_W-1:0] cfg_data;

	logic [ROW_W-1:0] matrix [NUM_ROWS];
	out_word_t expected_words [$];
	dir_row_t dir_rows [$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int settings = 0;
	int wz_seen = 0;
	int clip_seen = 0;
	int in_pct = 0;
	int out_pct = 0;
	int hold_req = 0;

	homogeneous_point_transform_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint coef_of(int r, int c);
		return longint'($signed(matrix[r][16*c +: 16]));
	endfunction

	function automatic out_word_t transform_point(in_word_t p);
		longint acc [4];
		longint unsigned m;
		longint unsigned mw;
		logic neg;
		logic wz;
		logic [COORD_W-1:0] v;
		out_word_t r;
		begin
			for (int c = 0; c < 4; c++)
				acc[c] = longint'(p.in_x) * coef_of(0, c) + longint'(p.in_y) * coef_of(1, c)
					+ longint'(p.in_z) * coef_of(2, c) + coef_of(3, c) * 65536;
			wz = (acc[3] == 0);
			mw = acc[3] < 0 ? longint'(-acc[3]) : acc[3];
			r.clipped = 1'b0;
			for (int c = 0; c < 3; c++) begin
				m = acc[c] < 0 ? longint'(-acc[c]) : acc[c];
				if (wz) begin
					m = m >> 8;
					neg = acc[c] < 0;
				end else begin
					m = (m << 16) / mw;
					neg = (acc[c] < 0) != (acc[3] < 0);
				end
				if (neg && m > 64'h8000_0000) begin
					v = SAT_MIN;
					r.clipped = 1'b1;
				end else if (!neg && m > 64'h7FFF_FFFF) begin
					v = SAT_MAX;
					r.clipped = 1'b1;
				end else
					v = neg ? COORD_W'(0) - m[31:0] : m[31:0];
				case (c)
					0: r.out_x = v;
					1: r.out_y = v;
					default: r.out_z = v;
				endcase
			end
			r.w_was_zero = wz;
			return r;
		end
	endfunction

	function automatic in_word_t mk_pt(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		in_word_t p;
		begin
			p.in_x = x;
			p.in_y = y;
			p.in_z = z;
			return p;
		end
	endfunction

	function automatic out_word_t mk_out(logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic wz, logic cl);
		out_word_t o;
		begin
			o.out_x = x;
			o.out_y = y;
			o.out_z = z;
			o.w_was_zero = wz;
			o.clipped = cl;
			return o;
		end
	endfunction

	task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
		dir_row_t d;
		begin
			d.kind = DIR_CFG;
			d.idx = idx;
			d.data = data;
			d.has_exp = 1'b0;
			dir_rows.push_back(d);
		end
	endtask

	task automatic add_point(in_word_t p, logic has_exp, out_word_t e);
		dir_row_t d;
		begin
			d.kind = DIR_POINT;
			d.pt = p;
			d.has_exp = has_exp;
			d.exp = e;
			dir_rows.push_back(d);
		end
	endtask

	task automatic wait_idle();
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_row(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
		begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;
			if (idx < NUM_ROWS)
				matrix[idx] = data;
			settings++;
			@(posedge clk);
		end
	endtask

	task automatic send_point(in_word_t p, logic has_exp, out_word_t e);
		out_word_t pred;
		begin
			while ($urandom_range(99) < in_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			in_word <= p;
			do @(posedge clk); while (in_stall);
			pred = transform_point(p);
			expected_words.push_back(has_exp ? e : pred);
			sent++;
		end
	endtask

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(5))
			0: return 16'($signed($urandom_range(1024)) - 512);
			1: return 16'($urandom);
			2: return 16'h7FFF;
			3: return 16'h8000;
			4: return 16'h0000;
			default: return 16'h0100;
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(4))
			0: return $urandom;
			1: return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: return 32'($signed($urandom_range(512)) - 256);
			default: return $urandom;
		endcase
	endfunction

	// receiver with random stall and a long hold on request
	initial begin : receiver
		int hold_cnt;
		int hold_seen;
		out_word_t e;
		hold_cnt = 0;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("output word with no expectation: %h", out_word);
					errors++;
				end else begin
					e = expected_words.pop_front();
					checked++;
					if (out_word.w_was_zero) wz_seen++;
					if (out_word.clipped) clip_seen++;
					if (out_word.out_x !== e.out_x) begin
						$error("out_x expected %h got %h", e.out_x, out_word.out_x);
						errors++;
					end
					if (out_word.out_y !== e.out_y) begin
						$error("out_y expected %h got %h", e.out_y, out_word.out_y);
						errors++;
					end
					if (out_word.out_z !== e.out_z) begin
						$error("out_z expected %h got %h", e.out_z, out_word.out_z);
						errors++;
					end
					if (out_word.w_was_zero !== e.w_was_zero) begin
						$error("w_was_zero expected %b got %b", e.w_was_zero,
							out_word.w_was_zero);
						errors++;
					end
					if (out_word.clipped !== e.clipped) begin
						$error("clipped expected %b got %b", e.clipped, out_word.clipped);
						errors++;
					end
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_cnt = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(99) < out_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("timeout with %0d words outstanding", expected_words.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		out_word_t none;
		int pmode;
		logic [ROW_W-1:0] row;
		none = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		matrix[0] = ROW0_RESET;
		matrix[1] = ROW1_RESET;
		matrix[2] = ROW2_RESET;
		matrix[3] = ROW3_RESET;

		// identity after reset
		add_point(mk_pt(0, 0, 0), 1'b1, mk_out(0, 0, 0, 1'b0, 1'b0));
		add_point(mk_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1,
			mk_out(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0));
		add_point(mk_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1,
			mk_out(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0));
		add_point(mk_pt(32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA), 1'b1,
			mk_out(32'h0001_0000, 32'hFFFF_0000, 32'h5555_AAAA, 1'b0, 1'b0));
		// out-of-range index is ignored
		add_cfg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
		add_point(mk_pt(32'h0000_1234, 0, 32'hFFFF_FFFF), 1'b1,
			mk_out(32'h0000_1234, 0, 32'hFFFF_FFFF, 1'b0, 1'b0));
		// w forced to zero: undivided pass-through
		add_cfg(REG_ROW3, 64'h0);
		add_point(mk_pt(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001), 1'b1,
			mk_out(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 1'b0));
		add_point(mk_pt(0, 0, 0), 1'b1, mk_out(0, 0, 0, 1'b1, 1'b0));
		// negative w
		add_cfg(REG_ROW3, 64'hFF00_0000_0000_0000);
		add_point(mk_pt(32'h8000_0000, 0, 0), 1'b1, mk_out(SAT_MAX, 0, 0, 1'b0, 1'b1));
		add_point(mk_pt(32'h0003_0000, 32'hFFFE_0000, 32'h7FFF_FFFF), 1'b0, none);
		// large scale: quotient saturates
		add_cfg(REG_ROW3, ROW3_RESET);
		add_cfg(REG_ROW0, 64'h0000_0000_0000_7FFF);
		add_point(mk_pt(32'h7FFF_FFFF, 0, 0), 1'b1, mk_out(SAT_MAX, 0, 0, 1'b0, 1'b1));
		add_point(mk_pt(32'h8000_0000, 0, 0), 1'b1, mk_out(SAT_MIN, 0, 0, 1'b0, 1'b1));
		// extreme coefficients in rows 0, 1 and 3, smallest nonzero ones in rows 2 and 3
		add_cfg(REG_ROW0, 64'h8000_7FFF_8000_7FFF);
		add_cfg(REG_ROW1, 64'h7FFF_8000_7FFF_8000);
		add_cfg(REG_ROW2, 64'hFFFF_0001_FFFF_0001);
		add_cfg(REG_ROW3, 64'h0001_FFFF_8000_7FFF);
		add_point(mk_pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001), 1'b0, none);
		add_point(mk_pt(32'h0000_0100, 32'hFFFF_FF00, 32'h1234_5678), 1'b0, none);
		add_point(mk_pt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, none);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == DIR_CFG) begin
				in_valid <= 1'b0;
				wait_idle();
				write_row(dir_rows[i].idx, dir_rows[i].data);
			end else
				send_point(dir_rows[i].pt, dir_rows[i].has_exp, dir_rows[i].exp);
		end
		in_valid <= 1'b0;

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			in_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 18 : 62) : 0;
			out_pct = (ph % 4 == 2) ? 62 : (ph % 4 == 3 ? 18 : 0);
			for (int r = 0; r < NUM_ROWS; r++) begin
				for (int c = 0; c < 4; c++)
					row[16*c +: 16] = rand_coef();
				// some settings drive w to zero
				if (ph % 3 == 2)
					row[63:48] = 16'h0000;
				else if (r == 3 && row[63:48] == 16'h0000)
					row[63:48] = 16'h0100;
				write_row(CFG_IDX_W'(r), row);
			end
			if (ph == 0 || ph == 5)
				hold_req++;
			for (int n = 0; n < RAND_POINTS; n++) begin
				pmode = $urandom_range(3);
				send_point(mk_pt(rand_coord(), pmode == 0 ? 32'h0 : rand_coord(),
					rand_coord()), 1'b0, none);
			end
			in_valid <= 1'b0;
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_words.size() != 0) begin
			$error("%0d expected words never arrived", expected_words.size());
			errors++;
		end
		$display("sent %0d points over %0d register writes, checked %0d words",
			sent, settings, checked);
		$display("w zero in %0d words, saturation in %0d words", wz_seen, clip_seen);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* homogeneous_point_transform_top.f */
sv/hpt_pkg.sv
sv/hpt_front.sv
sv/hpt_queue.sv
sv/hpt_back.sv
sv/homogeneous_point_transform_top.sv
tb/sv/homogeneous_point_transform_top_tb.sv
